>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file tts_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/tts_pkg.sv
`default_nettype none
package tts_pkg;

  // tree geometry: full binary heap, root at node 1, leaves from LEAVES up
  localparam int LEAF_BITS  = 10;
  localparam int LEAVES     = 1 << LEAF_BITS;
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODES      = 2 * LEAVES;
  localparam int KEY_BITS   = 32;
  localparam int LIMIT_BITS = LEAF_BITS + 1;
  localparam int CMD_BITS   = 2;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_BITS  = ((LEAF_BITS + KEY_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((LEAF_BITS + KEY_BITS + 7) / 8) * 8;

  localparam logic [KEY_BITS-1:0]   KEY_INF     = {KEY_BITS{1'b1}};
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(LEAVES);
  localparam logic [NODE_BITS-1:0]  ROOT_NODE   = NODE_BITS'(1);

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;

  // one access to the node memory
  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    logic [KEY_BITS-1:0]  wdata;
    logic [NODE_BITS-1:0] raddr;
  } ram_req_t;

  // one result from the walker
  typedef struct packed {
    logic [LEAF_BITS-1:0] best_index;
    logic [KEY_BITS-1:0]  best_value;
    logic                 index_error;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/tts_node_ram.sv
`default_nettype none
module tts_node_ram import tts_pkg::*; (
  input  wire logic                clk,
  input  wire ram_req_t            req,
  output logic [KEY_BITS-1:0]      rd_data
);

  logic [KEY_BITS-1:0] mem [NODES];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/tts_walker.sv
`default_nettype none
module tts_walker import tts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire logic [CMD_BITS-1:0]   cmd,
  input  wire logic [LEAF_BITS-1:0]  leaf,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [LIMIT_BITS-1:0] limit,
  output ram_req_t                   req,
  input  wire logic [KEY_BITS-1:0]   rd_data,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output res_t                       res
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_UP, ST_ROOT, ST_DOWN, ST_DONE
  } state_t;

  state_t               state, state_next;
  logic [NODE_BITS-1:0] node, node_next;
  logic [KEY_BITS-1:0]  cur, cur_next;
  logic [NODE_BITS-1:0] sweep, sweep_next;
  res_t                 res_next;

  logic [NODE_BITS-1:0] leaf_node, parent, down_node;
  logic [KEY_BITS-1:0]  up_min;
  logic                 in_range;

  // node arithmetic on heap indices
  assign leaf_node = {1'b1, leaf};
  assign parent    = {1'b0, node[NODE_BITS-1:1]};
  assign up_min    = (rd_data < cur) ? rd_data : cur;
  assign down_node = {node[NODE_BITS-2:0], ~(rd_data == res.best_value)};
  assign in_range  = {1'b0, leaf} < limit;

  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // next state and memory access
  always_comb begin
    state_next = state;
    node_next  = node;
    cur_next   = cur;
    sweep_next = sweep;
    res_next   = res;
    req.we     = 1'b0;
    req.waddr  = sweep;
    req.wdata  = KEY_INF;
    req.raddr  = ROOT_NODE;
    case (state)
      ST_INIT, ST_CLEAR: begin
        req.we     = 1'b1;
        sweep_next = sweep + NODE_BITS'(1);
        if (sweep == {NODE_BITS{1'b1}}) begin
          if (state == ST_INIT) begin
            state_next = ST_IDLE;
          end else begin
            res_next.best_value = KEY_INF;
            res_next.best_index = '0;
            state_next          = ST_DONE;
          end
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          res_next.index_error = 1'b0;
          case (cmd)
            CMD_CLEAR: begin
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            CMD_UPDATE: begin
              if (in_range) begin
                req.we     = 1'b1;
                req.waddr  = leaf_node;
                req.wdata  = key;
                req.raddr  = {leaf_node[NODE_BITS-1:1], ~leaf_node[0]};
                node_next  = leaf_node;
                cur_next   = key;
                state_next = ST_UP;
              end else begin
                res_next.index_error = 1'b1;
                state_next           = ST_ROOT;
              end
            end
            CMD_FIND: begin
              state_next = ST_ROOT;
            end
            default: begin
              state_next = ST_ROOT;
            end
          endcase
        end
      end
      ST_UP: begin
        // write the parent as min of the two children, fetch its sibling
        req.we    = 1'b1;
        req.waddr = parent;
        req.wdata = up_min;
        cur_next  = up_min;
        node_next = parent;
        if (parent == ROOT_NODE) begin
          res_next.best_value = up_min;
          req.raddr           = {ROOT_NODE[NODE_BITS-2:0], 1'b0};
          state_next          = ST_DOWN;
        end else begin
          req.raddr = {parent[NODE_BITS-1:1], ~parent[0]};
        end
      end
      ST_ROOT: begin
        res_next.best_value = rd_data;
        node_next           = ROOT_NODE;
        req.raddr           = {ROOT_NODE[NODE_BITS-2:0], 1'b0};
        state_next          = ST_DOWN;
      end
      ST_DOWN: begin
        // left child equal to the root minimum wins, else go right
        if (down_node[NODE_BITS-1]) begin
          res_next.best_index = down_node[LEAF_BITS-1:0];
          state_next          = ST_DONE;
        end else begin
          node_next = down_node;
          req.raddr = {down_node[NODE_BITS-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
    end
    node <= node_next;
    cur  <= cur_next;
    res  <= res_next;
  end

endmodule
`default_nettype wire

>>> hw/rtl/tournament_tree_min_select.sv
// commands: one at a time; a find walks down the 10 tree levels from the root, an update
//   walks up the 10 levels writing each parent and then back down, a clear sweeps every node
// reset: synchronous, sweeps all 2048 nodes to infinity with s_axis_tready low;
//   leaves_in_use returns to 1024
`default_nettype none
module tournament_tree_min_select import tts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // leaf_index [9:0], key_value [41:10], zero pad above
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // command [1:0]
  input  wire logic [CMD_BITS-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // best_index [9:0], best_value [41:10], zero pad above
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // index_error [0]
  output logic                          m_axis_tuser,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [LIMIT_BITS-1:0]    cfg_data
);

  logic [LIMIT_BITS-1:0] limit;
  ram_req_t              req;
  logic [KEY_BITS-1:0]   rd_data;
  logic                  res_valid, res_ready;
  res_t                  res;

  // leaves_in_use register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  tts_node_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  tts_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd       (s_axis_tuser),
    .leaf      (s_axis_tdata[LEAF_BITS-1:0]),
    .key       (s_axis_tdata[LEAF_BITS+KEY_BITS-1:LEAF_BITS]),
    .limit     (limit),
    .req       (req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, loads whenever empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      m_axis_tdata <= OUT_DATA_BITS'({res.best_value, res.best_index});
      m_axis_tuser <= res.index_error;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tts_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tts_checker import tts_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_axis_tvalid,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire logic                     m_axis_tuser
);

  logic all_inf;
  assign all_inf = (m_axis_tdata[LEAF_BITS+KEY_BITS-1:LEAF_BITS] == KEY_INF);

  // reset starts the clearing sweep, no beat taken straight after
  `ASSERT_NEXT_ALWAYS(a_reset_busy, clk, rst, !s_axis_tready)

  // one command at a time: busy after an accepted beat
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // an empty tree reports leaf 0
  `ASSERT_IMPL(a_inf_index, clk, rst, m_axis_tvalid && all_inf,
               m_axis_tdata[LEAF_BITS-1:0] == '0)

endmodule

bind tournament_tree_min_select tts_checker u_tts_checker (.*);
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb import tts_pkg::*; ();

  // unused command code, handled by the block as a find
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned NO_BEAT_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS   = 155;

  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [LEAF_BITS-1:0] leaf;
    logic [KEY_BITS-1:0]  key;
  } tree_cmd_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic [CMD_BITS-1:0]      s_axis_tuser = CMD_CLEAR;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LIMIT_BITS-1:0]    cfg_data = '0;

  tournament_tree_min_select u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // clock and reset
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // shadow copy of the leaves and the update limit
  logic [KEY_BITS-1:0]   shadow_keys [LEAVES];
  logic [LIMIT_BITS-1:0] shadow_limit;

  tree_cmd_t   pending_cmd_q [$];
  res_t        pending_min_q [$];
  int unsigned mismatches = 0;
  int unsigned n_clear = 0, n_update = 0, n_find = 0, n_refused = 0;
  int unsigned n_checked = 0, n_cfg = 0;
  int unsigned done_cnt = 0;

  // apply one command to the shadow leaves, return root minimum and its lowest leaf
  function automatic res_t tree_min_after(tree_cmd_t c);
    res_t r;
    int unsigned i;
    r.index_error = 1'b0;
    case (c.cmd)
      CMD_CLEAR: begin
        for (i = 0; i < LEAVES; i++) shadow_keys[i] = KEY_INF;
      end
      CMD_UPDATE: begin
        if ({1'b0, c.leaf} < shadow_limit) shadow_keys[c.leaf] = c.key;
        else r.index_error = 1'b1;
      end
      default: ;
    endcase
    // strict compare keeps the lowest index among equal keys
    r.best_index = '0;
    r.best_value = shadow_keys[0];
    for (i = 1; i < LEAVES; i++) begin
      if (shadow_keys[i] < r.best_value) begin
        r.best_value = shadow_keys[i];
        r.best_index = LEAF_BITS'(i);
      end
    end
    return r;
  endfunction

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned draw_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic tree_cmd_t random_cmd(logic [LIMIT_BITS-1:0] lim);
    tree_cmd_t   c;
    int unsigned r, top;
    r = $urandom_range(0, 99);
    if (r < 3) c.cmd = CMD_CLEAR;
    else if (r < 72) c.cmd = CMD_UPDATE;
    else if (r < 95) c.cmd = CMD_FIND;
    else c.cmd = CMD_UNUSED;
    // mostly leaves that accept the write, some anywhere
    top = (lim > LEAVES) ? LEAVES - 1 : lim - 1;
    if (lim != 0 && $urandom_range(0, 99) < 80) c.leaf = LEAF_BITS'($urandom_range(0, top));
    else c.leaf = LEAF_BITS'($urandom_range(0, LEAVES - 1));
    // small keys give plenty of ties
    r = $urandom_range(0, 99);
    if (r < 35) c.key = KEY_BITS'($urandom_range(0, 15));
    else if (r < 45) c.key = KEY_INF;
    else if (r < 50) c.key = '0;
    else if (r < 75) c.key = $urandom >> $urandom_range(0, 31);
    else c.key = $urandom;
    return c;
  endfunction

  // command driver
  tree_cmd_t   cur_cmd = '0;
  int unsigned src_gap = 0, src_calm = 0, sent_cnt = 0;
  logic        src_drain = 1'b0;

  always @(posedge clk) begin
    res_t want;
    logic show;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      show = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        want = tree_min_after(cur_cmd);
        pending_min_q.push_back(want);
        sent_cnt++;
        case (cur_cmd.cmd)
          CMD_CLEAR:  n_clear++;
          CMD_UPDATE: n_update++;
          default:    n_find++;
        endcase
        if (want.index_error) n_refused++;
        show = 1'b0;
        src_gap = draw_idle(src_calm);
        // now and then hold off until every result is back
        if ($urandom_range(0, 99) < 2) src_drain = 1'b1;
      end
      if (!show) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (src_drain && sent_cnt != done_cnt) begin
        end else if (pending_cmd_q.size() != 0) begin
          src_drain = 1'b0;
          cur_cmd = pending_cmd_q.pop_front();
          show = 1'b1;
        end
      end
      s_axis_tvalid <= show;
      s_axis_tdata  <= IN_DATA_BITS'({cur_cmd.key, cur_cmd.leaf});
      s_axis_tuser  <= cur_cmd.cmd;
    end
  end

  // result monitor
  int unsigned sink_stall = 0, sink_calm = 0;

  always @(posedge clk) begin
    res_t                 want;
    logic [LEAF_BITS-1:0] got_index;
    logic [KEY_BITS-1:0]  got_value;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_index = m_axis_tdata[LEAF_BITS-1:0];
        got_value = m_axis_tdata[LEAF_BITS +: KEY_BITS];
        if (pending_min_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, index %0d value %h",
                   $time, got_index, got_value);
          mismatches++;
        end else begin
          want = pending_min_q.pop_front();
          if (got_index !== want.best_index) begin
            $display("%0t: best_index expected %0d, got %0d", $time, want.best_index, got_index);
            mismatches++;
          end
          if (got_value !== want.best_value) begin
            $display("%0t: best_value expected %h, got %h", $time, want.best_value, got_value);
            mismatches++;
          end
          if (m_axis_tuser !== want.index_error) begin
            $display("%0t: index_error expected %0b, got %0b", $time, want.index_error,
                     m_axis_tuser);
            mismatches++;
          end
        end
        n_checked++;
        done_cnt <= done_cnt + 1;
        sink_stall = draw_idle(sink_calm);
      end else if (!m_axis_tvalid && sink_stall == 0 && $urandom_range(0, 99) < 4) begin
        sink_stall = $urandom_range(1, 8);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat anywhere
  int unsigned no_beat = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      no_beat <= 0;
    end else if (no_beat == NO_BEAT_LIMIT) begin
      $display("%0t: no beat for %0d cycles, giving up", $time, NO_BEAT_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      no_beat <= no_beat + 1;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmd_q.size() != 0 || s_axis_tvalid || pending_min_q.size() != 0)
      @(negedge clk);
  endtask

  // limit write, only with the block drained
  task automatic write_limit(input logic [LIMIT_BITS-1:0] lim);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_limit = lim;
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic push_cmd(input logic [CMD_BITS-1:0] cmd, input int unsigned leaf,
                          input logic [KEY_BITS-1:0] key);
    tree_cmd_t c;
    c.cmd  = cmd;
    c.leaf = LEAF_BITS'(leaf);
    c.key  = key;
    pending_cmd_q.push_back(c);
  endtask

  // stimulus
  initial begin
    logic [LIMIT_BITS-1:0] lim;
    int unsigned           i;
    for (i = 0; i < LEAVES; i++) shadow_keys[i] = KEY_INF;
    shadow_limit = LIMIT_RESET;
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: empty tree, ties, infinity keys, extreme leaves, at reset limit
    push_cmd(CMD_FIND,   0,    32'h0000_0000);
    push_cmd(CMD_UNUSED, 1023, KEY_INF);
    push_cmd(CMD_UPDATE, 1023, 32'h0000_0000);
    push_cmd(CMD_UPDATE, 0,    32'h0000_0000);
    push_cmd(CMD_UPDATE, 0,    KEY_INF);
    push_cmd(CMD_UPDATE, 512,  32'h0000_0000);
    push_cmd(CMD_UPDATE, 1023, 32'hAAAA_AAAA);
    push_cmd(CMD_UPDATE, 5,    32'h5555_5555);
    push_cmd(CMD_FIND,   341,  32'hFFFF_0000);
    push_cmd(CMD_CLEAR,  682,  32'h0000_FFFF);
    push_cmd(CMD_UPDATE, 1023, KEY_INF);
    push_cmd(CMD_UPDATE, 1,    32'hFFFF_FFFE);
    push_cmd(CMD_UNUSED, 0,    32'h1234_5678);
    push_cmd(CMD_UPDATE, 900,  32'h0000_0001);
    // lowered limit keeps leaf 900, leaves from 4 up are refused
    write_limit(11'd4);
    push_cmd(CMD_UPDATE, 3,    32'h0000_0007);
    push_cmd(CMD_UPDATE, 4,    32'h0000_0000);
    push_cmd(CMD_FIND,   0,    32'h0000_0000);
    push_cmd(CMD_UPDATE, 1023, 32'h0000_0000);
    // zero limit refuses every update
    write_limit(11'd0);
    push_cmd(CMD_UPDATE, 0,    32'h0000_0000);
    push_cmd(CMD_CLEAR,  0,    32'h0000_0000);
    // limit above the tree size
    write_limit(11'd2047);
    push_cmd(CMD_UPDATE, 1023, 32'h0000_0003);
    push_cmd(CMD_UPDATE, 0,    32'h0000_0003);

    // random phases over a spread of limits
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       lim = 11'd2047;
        1:       lim = 11'd1;
        2:       lim = 11'd2;
        3:       lim = 11'd8;
        4:       lim = LIMIT_RESET;
        5:       lim = 11'd33;
        7:       lim = 11'd0;
        8:       lim = 11'd16;
        9:       lim = 11'd512;
        11:      lim = LIMIT_RESET;
        default: lim = LIMIT_BITS'($urandom_range(1, LEAVES));
      endcase
      write_limit(lim);
      for (i = 0; i < PHASE_ITEMS; i++) pending_cmd_q.push_back(random_cmd(lim));
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("tb: %0d commands: %0d clear, %0d update (%0d refused), %0d find",
             n_clear + n_update + n_find, n_clear, n_update, n_refused, n_find);
    $display("tb: %0d results checked over %0d limit writes, %0d mismatches",
             n_checked, n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
